### design/euq_pkg.sv
// Shared constants and types for the Euler-angle to quaternion pipeline.
`default_nettype none
package euq_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_N = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int ZW = 34;
    localparam int CSW = 19;
    localparam int P2W = 2 * CSW;
    localparam int P3W = 3 * CSW;
    localparam int SUMW = P3W + 1;
    localparam int RNDW = SUMW - 31;
    localparam int LATENCY = CORDIC_N + 5;

    typedef logic signed [ZW-1:0] cword_t;
    typedef logic signed [CSW-1:0] cs_t;

    localparam cword_t CORDIC_GAIN = 34'sd652032874;
    localparam cword_t HALF_PI = 34'sd1686629713;
    localparam cword_t PI_VAL = 34'sd3373259426;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    localparam cword_t ATAN_Q30 [ATAN_ENTRIES] = '{
        34'h03243F6A8, 34'h01DAC6705, 34'h00FADBAFC, 34'h007F56EA6, 34'h003FEAB76,
        34'h001FFD55B, 34'h000FFFAAA, 34'h0007FFF55, 34'h0003FFFEA, 34'h0001FFFFD,
        34'h0000FFFFF, 34'h00007FFFF, 34'h00003FFFF, 34'h00001FFFF, 34'h00000FFFF,
        34'h000007FFF, 34'h000003FFF, 34'h000001FFF, 34'h000000FFF, 34'h0000007FF,
        34'h0000003FF, 34'h0000001FF, 34'h0000000FF, 34'h00000007F
    };
endpackage
`default_nettype wire

### design/euler_to_quaternion_core.sv
// Registers in order: CORDIC input, steps, cos/sin, pair products, triples, output.
// Throughput: one angle triple per cycle; one CORDIC stage per step per angle, but
// the whole pipeline holds while a result waits and the output is not ready.
// Reset: rst_n asynchronous, active low, clears all valid bits; no other state.
// Top level: Euler angles (ZYX) to unit quaternion.
`default_nettype none
module euler_to_quaternion_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata   // quat_x, quat_y, quat_z, quat_w
);
    localparam int L = euq_pkg::LATENCY;
    localparam int P2 = euq_pkg::P2W;
    localparam int P3 = euq_pkg::P3W;
    localparam int SW = euq_pkg::SUMW;
    localparam int RW = euq_pkg::RNDW;

    logic en;
    logic [L-1:0] vld_reg;
    logic [L-1:0] vld_next;
    euq_pkg::cs_t cr, sr, cp, sp, cy, sy;
    euq_pkg::cs_t cy_reg, sy_reg;
    logic signed [P2-1:0] srcp_reg, crsp_reg, crcp_reg, srsp_reg;
    logic signed [P3-1:0] p_reg [8];
    logic signed [SW-1:0] sum [4];
    logic signed [RW-1:0] rnd [4];
    logic [15:0] q_next [4];
    logic [15:0] q_reg [4];

    assign en = !vld_reg[L-1] || m_axis_tready;
    assign s_axis_tready = en;

    euq_half_cos_sin u_roll (.clk(clk), .en(en), .angle(s_axis_tdata[15:0]),
        .cos_q15(cr), .sin_q15(sr));
    euq_half_cos_sin u_pitch (.clk(clk), .en(en), .angle(s_axis_tdata[31:16]),
        .cos_q15(cp), .sin_q15(sp));
    euq_half_cos_sin u_yaw (.clk(clk), .en(en), .angle(s_axis_tdata[47:32]),
        .cos_q15(cy), .sin_q15(sy));

    assign vld_next = {vld_reg[L-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srcp_reg <= sr * cp;
            crsp_reg <= cr * sp;
            crcp_reg <= cr * cp;
            srsp_reg <= sr * sp;
            cy_reg <= cy;
            sy_reg <= sy;
            p_reg[0] <= srcp_reg * cy_reg;
            p_reg[1] <= crsp_reg * sy_reg;
            p_reg[2] <= crsp_reg * cy_reg;
            p_reg[3] <= srcp_reg * sy_reg;
            p_reg[4] <= crcp_reg * sy_reg;
            p_reg[5] <= srsp_reg * cy_reg;
            p_reg[6] <= crcp_reg * cy_reg;
            p_reg[7] <= srsp_reg * sy_reg;
            for (int k = 0; k < 4; k++)
            begin
                q_reg[k] <= q_next[k];
            end
        end
    end

    always_comb
    begin
        sum[0] = SW'(p_reg[0]) - SW'(p_reg[1]);
        sum[1] = SW'(p_reg[2]) + SW'(p_reg[3]);
        sum[2] = SW'(p_reg[4]) - SW'(p_reg[5]);
        sum[3] = SW'(p_reg[6]) + SW'(p_reg[7]);
        for (int k = 0; k < 4; k++)
        begin
            rnd[k] = RW'((sum[k] + (SW'(1) <<< 30)) >>> 31);
            if (rnd[k] > RW'(euq_pkg::Q14_ONE))
            begin
                q_next[k] = euq_pkg::Q14_ONE;
            end
            else if (rnd[k] < -RW'(euq_pkg::Q14_ONE))
            begin
                q_next[k] = -euq_pkg::Q14_ONE;
            end
            else
            begin
                q_next[k] = rnd[k][15:0];
            end
        end
    end

    assign m_axis_tvalid = vld_reg[L-1];
    assign m_axis_tdata = {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};

`ifndef SYNTHESIS
    a_ready_tracks_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                           $signed(m_axis_tdata[15:0]) >= -16'sd16384))
        else $error("quat_x out of range");
    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[63:48]) <= 16'sd16384 &&
                           $signed(m_axis_tdata[63:48]) >= -16'sd16384))
        else $error("quat_w out of range");
`endif
endmodule
`default_nettype wire

### design/euq_half_cos_sin.sv
// Pipelined CORDIC giving cosine and sine of half of one Q3.13 angle.
`default_nettype none
module euq_half_cos_sin (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [15:0]   angle,
    output logic signed [euq_pkg::CSW-1:0] cos_q15,
    output logic signed [euq_pkg::CSW-1:0] sin_q15
);
    localparam int N = euq_pkg::CORDIC_N;

    euq_pkg::cword_t z_reg [N+1];
    euq_pkg::cword_t x_reg [N+1];
    euq_pkg::cword_t y_reg [N+1];
    logic            flip_reg [N+1];
    euq_pkg::cword_t z_next;
    euq_pkg::cword_t x_rnd;
    euq_pkg::cword_t y_rnd;
    logic            flip_next;
    euq_pkg::cs_t    cos_next;
    euq_pkg::cs_t    sin_next;
    euq_pkg::cs_t    cos_reg;
    euq_pkg::cs_t    sin_reg;

    always_comb
    begin
        z_next = {{(euq_pkg::ZW-32){angle[15]}}, angle, 16'b0};
        flip_next = 1'b0;
        if (z_next > euq_pkg::HALF_PI)
        begin
            z_next = z_next - euq_pkg::PI_VAL;
            flip_next = 1'b1;
        end
        else if (z_next < -euq_pkg::HALF_PI)
        begin
            z_next = z_next + euq_pkg::PI_VAL;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0] <= z_next;
            x_reg[0] <= euq_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][euq_pkg::ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - euq_pkg::ATAN_Q30[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + euq_pkg::ATAN_Q30[i];
                end
            end
        end
    end

    always_comb
    begin
        x_rnd = (x_reg[N] + euq_pkg::ZW'(16384)) >>> 15;
        y_rnd = (y_reg[N] + euq_pkg::ZW'(16384)) >>> 15;
        cos_next = x_rnd[euq_pkg::CSW-1:0];
        sin_next = y_rnd[euq_pkg::CSW-1:0];
        if (flip_reg[N])
        begin
            cos_next = -cos_next;
            sin_next = -sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q15 = cos_reg;
    assign sin_q15 = sin_reg;
endmodule
`default_nettype wire

### dv/testbench.sv
// Testbench for euler_to_quaternion_core: angle triples checked against a ZYX predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 550;
    localparam int DIRECTED_ITEMS = 17;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } quat_t;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } angles_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;  // roll_angle, pitch_angle, yaw_angle
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;  // quat_x, quat_y, quat_z, quat_w

    quat_t quat_queue[$];
    int    errors;
    int    sent;
    int    checked;
    int    tx_idle_pct;
    int    rx_idle_pct;

    euler_to_quaternion_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void half_cos_sin(input logic signed [15:0] a,
                                         output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'(a) * 65536;
        x = longint'(euq_pkg::CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (z > longint'(euq_pkg::HALF_PI))
        begin
            z = z - longint'(euq_pkg::PI_VAL);
            flip = 1'b1;
        end
        else if (z < -longint'(euq_pkg::HALF_PI))
        begin
            z = z + longint'(euq_pkg::PI_VAL);
            flip = 1'b1;
        end
        for (int i = 0; i < euq_pkg::CORDIC_N; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(euq_pkg::ATAN_Q30[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(euq_pkg::ATAN_Q30[i]);
            end
            x = nx;
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [15:0] round_q14(input longint q45);
        longint v;
        v = (q45 + (longint'(1) << 30)) >>> 31;
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return v[15:0];
    endfunction

    function automatic quat_t zyx_quaternion(input angles_t a);
        longint cr, sr, cp, sp, cy, sy;
        quat_t  q;
        half_cos_sin(a.roll, cr, sr);
        half_cos_sin(a.pitch, cp, sp);
        half_cos_sin(a.yaw, cy, sy);
        q.x = round_q14(sr * cp * cy - cr * sp * sy);
        q.y = round_q14(cr * sp * cy + sr * cp * sy);
        q.z = round_q14(cr * cp * sy - sr * sp * cy);
        q.w = round_q14(cr * cp * cy + sr * sp * sy);
        return q;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", checked, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        quat_t got;
        quat_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            quat_queue.insert(quat_queue.size(),
                              zyx_quaternion('{s_axis_tdata[15:0], s_axis_tdata[31:16],
                                               s_axis_tdata[47:32]}));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (quat_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end
            else
            begin
                want = quat_queue.pop_front();
                if (got.x !== want.x)
                    report_mismatch($sformatf("quat_x got %0d expected %0d", got.x, want.x));
                if (got.y !== want.y)
                    report_mismatch($sformatf("quat_y got %0d expected %0d", got.y, want.y));
                if (got.z !== want.z)
                    report_mismatch($sformatf("quat_z got %0d expected %0d", got.z, want.z));
                if (got.w !== want.w)
                    report_mismatch($sformatf("quat_w got %0d expected %0d", got.w, want.w));
            end
            checked++;
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic send_angles(input angles_t a);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {a.yaw, a.pitch, a.roll};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'(25735 + $urandom_range(0, 2));
            1: return 16'(-25737 + $urandom_range(0, 2));
            2: return 16'($urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                                 : -32768 + $urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        angles_t table_rows[DIRECTED_ITEMS];
        angles_t a;
        int      wait_cycles;
        table_rows = '{
            '{16'sd0, 16'sd0, 16'sd0},
            '{16'sd32767, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd32767, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd32767},
            '{-16'sd32768, 16'sd0, 16'sd0},
            '{16'sd0, -16'sd32768, 16'sd0},
            '{16'sd0, 16'sd0, -16'sd32768},
            '{16'sd32767, 16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768, -16'sd32768},
            '{16'sd25735, 16'sd25736, -16'sd25735},
            '{-16'sd25736, 16'sd25735, 16'sd25736},
            '{16'sd12868, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd12868, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd12868},
            '{16'sd1, -16'sd1, 16'sd1},
            '{16'sd25736, 16'sd25736, 16'sd25736},
            '{16'h5555, 16'hAAAA, 16'h7FFE}
        };
        errors = 0;
        sent = 0;
        checked = 0;
        tx_idle_pct = 22;
        rx_idle_pct = 76;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (table_rows[i])
            send_angles(table_rows[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 76;
                rx_idle_pct = 22;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            a.roll = rand_angle();
            a.pitch = rand_angle();
            a.yaw = rand_angle();
            send_angles(a);
        end
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (quat_queue.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (2 * euq_pkg::LATENCY) @(negedge clk);
        if (quat_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", quat_queue.size()));
        $display("sent %0d angle triples (%0d directed), checked %0d quaternions",
                 sent, DIRECTED_ITEMS, checked);
        $display("covered half-angle wrap, full-scale angles and three stall mixes");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
